>>> rtl/lvm_pkg.sv
package lvm_pkg;

    // Default strip capacity
    localparam int MAX_LEDS_DEF = 64;

    // Field widths
    localparam int AMP_W   = 12;
    localparam int LEN_W   = 7;
    localparam int SENS_W  = 7;
    localparam int MODE_W  = 2;
    localparam int COLOR_W = 24;
    localparam int IDX_W   = 6;
    localparam int DECAY_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Gain = (100 + 9*sensitivity) / 100
    localparam int GAIN_W    = 11;
    localparam int GAIN_BASE = 100;
    localparam int GAIN_STEP = 9;

    // Scale: divide by 409600 = 2^14 * 25
    localparam int PROD1_W     = AMP_W + GAIN_W;
    localparam int PROD2_W     = PROD1_W + LEN_W;
    localparam int SCALE_SHIFT = 14;
    localparam int QUOT_IN_W   = PROD2_W - SCALE_SHIFT;
    localparam int DIV_CONST   = 25;
    localparam int RECIP       = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 17;
    localparam int RPROD_W     = QUOT_IN_W + RECIP_W;
    localparam int Q_W         = RPROD_W - RECIP_SHIFT;
    localparam int QCHK_W      = Q_W + 5;

    // Peak decay
    localparam int DECAY_PERIOD = 51;

    // Reset values and colours
    localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(64);
    localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] PEAK_RGB    = 24'hFF0000;
    localparam logic [COLOR_W-1:0] BLACK_RGB   = 24'h000000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR     = 2'd3;

    // Layouts
    localparam logic [MODE_W-1:0] MODE_BOTTOM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CENTRE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOP    = 2'd2;

    // Operations
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Controller states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL1  = 6'b000010,
        S_MUL2  = 6'b000100,
        S_DIV   = 6'b001000,
        S_COUNT = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_frame;
        logic tick;
        logic mul1;
        logic mul2;
        logic divide;
        logic count;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic last;
    } status_t;

endpackage

>>> rtl/lvm_ctrl.sv
module lvm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  lvm_pkg::status_t  status,
    output lvm_pkg::cmd_t     cmd
);

    lvm_pkg::state_t state_reg, state_next;
    logic            accept;

    assign s_ready = (state_reg == lvm_pkg::S_IDLE);
    assign accept  = s_valid && s_ready;

    // Sequencing of one frame, and acceptance of ticks in idle
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lvm_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_operation == lvm_pkg::OP_TICK) begin
                        cmd.tick = 1'b1;
                    end else begin
                        cmd.load_frame = 1'b1;
                        state_next     = lvm_pkg::S_MUL1;
                    end
                end
            end
            lvm_pkg::S_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = lvm_pkg::S_MUL2;
            end
            lvm_pkg::S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = lvm_pkg::S_DIV;
            end
            lvm_pkg::S_DIV: begin
                cmd.divide = 1'b1;
                state_next = lvm_pkg::S_COUNT;
            end
            lvm_pkg::S_COUNT: begin
                cmd.count  = 1'b1;
                state_next = lvm_pkg::S_EMIT;
            end
            lvm_pkg::S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last) begin
                        state_next = lvm_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = lvm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lvm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/lvm_datapath.sv
module lvm_datapath #(
    parameter int MAX_LEDS = lvm_pkg::MAX_LEDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lvm_pkg::cmd_t                   cmd,
    output lvm_pkg::status_t                status,
    input  logic [lvm_pkg::AMP_W-1:0]       s_amplitude,
    input  logic                            cfg_valid,
    input  logic [lvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lvm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lvm_pkg::IDX_W-1:0]       m_led_index,
    output logic [7:0]                      m_red,
    output logic [7:0]                      m_green,
    output logic [7:0]                      m_blue,
    output logic                            m_last_led
);

    localparam int LW = lvm_pkg::LEN_W;

    // Configuration registers
    logic [LW-1:0]                    strip_len_reg;
    logic [lvm_pkg::SENS_W-1:0]       sens_reg;
    logic [lvm_pkg::MODE_W-1:0]       mode_reg;
    logic [lvm_pkg::COLOR_W-1:0]      color_reg;

    // Frame datapath
    logic [lvm_pkg::AMP_W-1:0]        amp_reg;
    logic [LW-1:0]                    len_reg;
    logic [LW-1:0]                    len_used;
    logic [lvm_pkg::GAIN_W-1:0]       gain;
    logic [lvm_pkg::PROD1_W-1:0]      prod1_reg;
    logic [lvm_pkg::PROD2_W-1:0]      prod2_reg;
    logic [lvm_pkg::QUOT_IN_W-1:0]    t_reg;
    logic [lvm_pkg::Q_W-1:0]          q0_reg;
    logic [lvm_pkg::RPROD_W-1:0]      rprod;
    logic [lvm_pkg::QCHK_W-1:0]       qchk;
    logic [lvm_pkg::Q_W-1:0]          qfix;
    logic [LW-1:0]                    count_next;
    logic [LW-1:0]                    count_reg;

    // Held peak
    logic [LW-1:0]                    peak_reg, peak_next;
    logic [lvm_pkg::DECAY_W-1:0]      decay_reg, decay_next;

    // LED walk and output register
    logic [LW-1:0]                    idx_reg;
    logic                             m_valid_reg, m_valid_next;
    logic [lvm_pkg::IDX_W-1:0]        led_index_reg;
    logic [lvm_pkg::COLOR_W-1:0]      rgb_reg;
    logic                             last_reg;
    logic                             last_led;
    logic                             lit, mark;
    logic [lvm_pkg::COLOR_W-1:0]      rgb;
    logic [LW:0]                      i8, c8, h8, ph8, cnt8, pk8, len8;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_len_reg <= lvm_pkg::LEN_RESET;
            sens_reg      <= '0;
            mode_reg      <= lvm_pkg::MODE_BOTTOM;
            color_reg     <= lvm_pkg::COLOR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lvm_pkg::REG_STRIP_LEN: strip_len_reg <= cfg_data[LW-1:0];
                lvm_pkg::REG_SENS:      sens_reg <= cfg_data[lvm_pkg::SENS_W-1:0];
                lvm_pkg::REG_MODE:      mode_reg <= cfg_data[lvm_pkg::MODE_W-1:0];
                lvm_pkg::REG_COLOR:     color_reg <= cfg_data[lvm_pkg::COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Strip length in use: zero acts as one, capped at capacity
    always_comb begin
        len_used = strip_len_reg;
        if (strip_len_reg == '0) begin
            len_used = LW'(1);
        end else if (int'(strip_len_reg) > MAX_LEDS) begin
            len_used = LW'(MAX_LEDS);
        end
    end

    assign gain = lvm_pkg::GAIN_W'(lvm_pkg::GAIN_BASE)
                + lvm_pkg::GAIN_W'(sens_reg) * lvm_pkg::GAIN_W'(lvm_pkg::GAIN_STEP);

    function automatic logic [lvm_pkg::QCHK_W-1:0] t_reg_q0_mul(
        input logic [lvm_pkg::Q_W-1:0] q
    );
        logic [lvm_pkg::QCHK_W-1:0] qw;
        qw = lvm_pkg::QCHK_W'(q);
        return (qw << 4) + (qw << 3) + qw;
    endfunction

    // Reciprocal of 25 on the scaled product, then one-step correction and clamp
    assign rprod = lvm_pkg::RPROD_W'(prod2_reg[lvm_pkg::PROD2_W-1:lvm_pkg::SCALE_SHIFT])
                 * lvm_pkg::RPROD_W'(lvm_pkg::RECIP);
    assign qchk  = lvm_pkg::QCHK_W'(t_reg_q0_mul(q0_reg));
    assign qfix  = (qchk > lvm_pkg::QCHK_W'(t_reg)) ? q0_reg - 1'b1 : q0_reg;
    assign count_next = (qfix > lvm_pkg::Q_W'(len_reg)) ? len_reg : qfix[LW-1:0];

    // Multiply and scale stages
    always_ff @(posedge aclk) begin
        if (cmd.load_frame) begin
            amp_reg <= s_amplitude;
            len_reg <= len_used;
        end
        if (cmd.mul1) begin
            prod1_reg <= lvm_pkg::PROD1_W'(amp_reg) * lvm_pkg::PROD1_W'(gain);
        end
        if (cmd.mul2) begin
            prod2_reg <= lvm_pkg::PROD2_W'(prod1_reg) * lvm_pkg::PROD2_W'(len_reg);
        end
        if (cmd.divide) begin
            t_reg <= prod2_reg[lvm_pkg::PROD2_W-1:lvm_pkg::SCALE_SHIFT];
        end
        if (cmd.count) begin
            count_reg <= count_next;
        end
    end

    // q0 is taken together with t, so the correction sees a matching pair
    always_ff @(posedge aclk) begin
        if (cmd.divide) begin
            q0_reg <= rprod[lvm_pkg::RPROD_W-1:lvm_pkg::RECIP_SHIFT];
        end
    end

    // Peak rise on frames, decay on ticks
    always_comb begin
        peak_next  = peak_reg;
        decay_next = decay_reg;
        if (cmd.count) begin
            if (count_next > peak_reg) begin
                peak_next = count_next;
            end
        end else if (cmd.tick) begin
            if (decay_reg == lvm_pkg::DECAY_W'(lvm_pkg::DECAY_PERIOD - 1)) begin
                decay_next = '0;
                if (peak_reg != '0) begin
                    peak_next = peak_reg - 1'b1;
                end
            end else begin
                decay_next = decay_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            decay_reg <= '0;
        end else begin
            peak_reg  <= peak_next;
            decay_reg <= decay_next;
        end
    end

    // Per-LED colour
    assign i8   = {1'b0, idx_reg};
    assign len8 = {1'b0, len_reg};
    assign c8   = {2'b0, len_reg[LW-1:1]};
    assign h8   = {2'b0, count_reg[LW-1:1]};
    assign ph8  = {2'b0, peak_reg[LW-1:1]};
    assign cnt8 = {1'b0, count_reg};
    assign pk8  = {1'b0, peak_reg};

    always_comb begin
        case (mode_reg)
            lvm_pkg::MODE_CENTRE: begin
                lit  = (h8 != '0) && (i8 + h8 > c8) && (i8 < c8 + h8);
                mark = (i8 == c8 + ph8) || (i8 + ph8 == c8);
            end
            lvm_pkg::MODE_TOP: begin
                lit  = (cnt8 != '0) && (i8 + cnt8 >= len8);
                mark = (i8 + pk8 == len8);
            end
            default: begin
                lit  = (idx_reg < count_reg);
                mark = (idx_reg == peak_reg);
            end
        endcase
        if (mark) begin
            rgb = lvm_pkg::PEAK_RGB;
        end else if (lit) begin
            rgb = color_reg;
        end else begin
            rgb = lvm_pkg::BLACK_RGB;
        end
    end

    assign last_led = (i8 + 1'b1 == len8);

    // LED counter
    always_ff @(posedge aclk) begin
        if (cmd.count) begin
            idx_reg <= '0;
        end else if (cmd.emit) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            led_index_reg <= idx_reg[lvm_pkg::IDX_W-1:0];
            rgb_reg       <= rgb;
            last_reg      <= last_led;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign status.last     = last_led;

    assign m_valid     = m_valid_reg;
    assign m_led_index = led_index_reg;
    assign m_red       = rgb_reg[23:16];
    assign m_green     = rgb_reg[15:8];
    assign m_blue      = rgb_reg[7:0];
    assign m_last_led  = last_reg;

endmodule

>>> rtl/led_vu_meter_peak_hold_unit.sv
// Frame item: after the multiply, scale and clamp steps, one LED per cycle is emitted
// while m_ready is high; no new item is taken until the frame's last LED is emitted.
// Tick item: no result; the next item may follow at once.
// aresetn (synchronous, active low) restores register defaults, clears peak and tick count.
module led_vu_meter_peak_hold_unit #(
    parameter int MAX_LEDS = lvm_pkg::MAX_LEDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [lvm_pkg::AMP_W-1:0]       s_amplitude,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lvm_pkg::IDX_W-1:0]       m_led_index,
    output logic [7:0]                      m_red,
    output logic [7:0]                      m_green,
    output logic [7:0]                      m_blue,
    output logic                            m_last_led,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lvm_pkg::cmd_t    cmd;
    lvm_pkg::status_t status;

    // Register writes always complete at once
    assign cfg_ready = 1'b1;

    lvm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .status      (status),
        .cmd         (cmd)
    );

    lvm_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_amplitude (s_amplitude),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_led_index (m_led_index),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_last_led  (m_last_led)
    );

endmodule

>>> rtl/lvm_checker.sv
module lvm_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_operation,
    input  logic [lvm_pkg::AMP_W-1:0]       s_amplitude,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [lvm_pkg::IDX_W-1:0]       m_led_index,
    input  logic [7:0]                      m_red,
    input  logic [7:0]                      m_green,
    input  logic [7:0]                      m_blue,
    input  logic                            m_last_led,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // No results straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_index) && $stable(m_red)
            && $stable(m_green) && $stable(m_blue) && $stable(m_last_led))
        else $error("stalled result changed");

    // A frame blocks the input while it is worked on
    a_frame_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == lvm_pkg::OP_FRAME) |=> !s_ready)
        else $error("input ready right after a frame");

    // LEDs of a frame follow each other without gaps
    a_led_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_led
            |=> m_valid && (m_led_index == $past(m_led_index) + 6'd1))
        else $error("LED sequence broken");

    // A tick never starts results
    a_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == lvm_pkg::OP_TICK) && !m_valid |=> !m_valid)
        else $error("tick produced a result");

endmodule

bind led_vu_meter_peak_hold_unit lvm_checker u_lvm_checker (.*);
